### sv/rbd_pkg.sv
package rbd_pkg;

    // Storage geometry of the deque.
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the transaction ports.
    localparam int KIND_W  = 3;
    localparam int POS_W   = 4;
    localparam int OUT_W   = 32;
    localparam int COUNT_W = 5;

    // Derived widths.
    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = PTR_W + POS_W + 2;

    // Depth of the command queue between the front and back parts.
    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_PEEK_INDEX = 3'd4,
        K_PEEK_FRONT = 3'd5,
        K_PEEK_BACK  = 3'd6,
        K_CLEAR      = 3'd7
    } t_kind;

    // Where the data of a result comes from.
    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_MEM  = 2'd1,
        SRC_FB   = 2'd2
    } t_src;

    // One decoded command as it travels through the queue.
    typedef struct packed {
        t_kind                  kind;
        logic                   wr;
        logic                   rd;
        logic [DATA_WIDTH-1:0]  data;
        logic [OUT_W-1:0]       fallback;
        logic [POS_W-1:0]       position;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == '0) begin
            r = PTR_W'(CAPACITY - 1);
        end else begin
            r = p - PTR_W'(1);
        end
        return r;
    endfunction

endpackage

### sv/rbd_front.sv
module rbd_front (
    input  logic                          i_start,
    input  logic [rbd_pkg::KIND_W-1:0]    i_kind,
    input  logic [31:0]                   i_data_in,
    input  logic [rbd_pkg::OUT_W-1:0]     i_fallback,
    input  logic [rbd_pkg::POS_W-1:0]     i_position,
    input  rbd_pkg::t_q_stat              i_q_stat,
    output logic                          o_busy,
    output logic                          o_push,
    output rbd_pkg::t_cmd                 o_cmd
);
    import rbd_pkg::*;

    t_kind kind;

    assign kind   = t_kind'(i_kind);
    assign o_busy = i_q_stat.full;
    assign o_push = i_start && !i_q_stat.full;

    // Classify the operation so the back part only has to steer pointers.
    always_comb begin
        o_cmd          = '0;
        o_cmd.kind     = kind;
        o_cmd.data     = DATA_WIDTH'(i_data_in);
        o_cmd.fallback = i_fallback;
        o_cmd.position = i_position;
        case (kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
                o_cmd.wr = 1'b1;
            end
            K_POP_FRONT, K_POP_BACK, K_PEEK_INDEX, K_PEEK_FRONT, K_PEEK_BACK: begin
                o_cmd.rd = 1'b1;
            end
            default: begin
                o_cmd.wr = 1'b0;
                o_cmd.rd = 1'b0;
            end
        endcase
    end

endmodule

### sv/rbd_cmd_q.sv
module rbd_cmd_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rbd_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output rbd_pkg::t_cmd     o_cmd,
    output rbd_pkg::t_q_stat  o_stat
);
    import rbd_pkg::*;

    t_cmd              r_q [Q_DEPTH];
    logic [QP_W-1:0]   r_wp, n_wp;
    logic [QP_W-1:0]   r_rp, n_rp;
    logic [QC_W-1:0]   r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QC_W'(Q_DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QP_W'(Q_DEPTH - 1)) ? '0 : r_wp + QP_W'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == QP_W'(Q_DEPTH - 1)) ? '0 : r_rp + QP_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

### sv/rbd_back.sv
module rbd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rbd_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic                          o_ok,
    output logic [rbd_pkg::OUT_W-1:0]     o_data_out,
    output logic [rbd_pkg::COUNT_W-1:0]   o_count,
    output logic [rbd_pkg::CNT_W-1:0]     o_fill
);
    import rbd_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_fill, n_fill;

    logic             r_res_valid;
    logic             r_ok, n_ok;
    t_src             r_src, n_src;
    logic [OUT_W-1:0] r_fallback;

    logic             full, empty, pos_ok, we;
    logic [PTR_W-1:0] head_dec, tail_dec, waddr, raddr, peek_addr;
    logic [IDX_W-1:0] idx_sum, idx_wrap;

    assign o_pop    = i_valid;
    assign full     = (r_fill == CNT_W'(CAPACITY));
    assign empty    = (r_fill == '0);
    assign head_dec = ptr_dec(r_head);
    assign tail_dec = ptr_dec(r_tail);
    assign pos_ok   = (IDX_W'(i_cmd.position) < IDX_W'(r_fill));

    // Counting back from the newest element: tail - 1 - position, wrapped once.
    assign idx_sum   = IDX_W'(r_tail) + IDX_W'(CAPACITY - 1) - IDX_W'(i_cmd.position);
    assign idx_wrap  = (idx_sum >= IDX_W'(CAPACITY)) ? idx_sum - IDX_W'(CAPACITY) : idx_sum;
    assign peek_addr = idx_wrap[PTR_W-1:0];

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        n_ok   = 1'b0;
        n_src  = SRC_ZERO;
        we     = 1'b0;
        waddr  = r_tail;
        raddr  = r_head;
        if (i_valid) begin
            case (i_cmd.kind)
                K_PUSH_FRONT: begin
                    waddr = head_dec;
                    if (!full) begin
                        we     = i_cmd.wr;
                        n_head = head_dec;
                        n_fill = r_fill + CNT_W'(1);
                        n_ok   = 1'b1;
                    end
                end
                K_PUSH_BACK: begin
                    waddr = r_tail;
                    if (!full) begin
                        we     = i_cmd.wr;
                        n_tail = ptr_inc(r_tail);
                        n_fill = r_fill + CNT_W'(1);
                        n_ok   = 1'b1;
                    end
                end
                K_POP_FRONT: begin
                    raddr = r_head;
                    n_src = SRC_FB;
                    if (!empty) begin
                        n_head = ptr_inc(r_head);
                        n_fill = r_fill - CNT_W'(1);
                        n_ok   = i_cmd.rd;
                        n_src  = SRC_MEM;
                    end
                end
                K_POP_BACK: begin
                    raddr = tail_dec;
                    n_src = SRC_FB;
                    if (!empty) begin
                        n_tail = tail_dec;
                        n_fill = r_fill - CNT_W'(1);
                        n_ok   = i_cmd.rd;
                        n_src  = SRC_MEM;
                    end
                end
                K_PEEK_INDEX: begin
                    raddr = peek_addr;
                    n_src = SRC_FB;
                    if (pos_ok) begin
                        n_ok  = i_cmd.rd;
                        n_src = SRC_MEM;
                    end
                end
                K_PEEK_FRONT: begin
                    raddr = r_head;
                    n_src = SRC_FB;
                    if (!empty) begin
                        n_ok  = i_cmd.rd;
                        n_src = SRC_MEM;
                    end
                end
                K_PEEK_BACK: begin
                    raddr = tail_dec;
                    n_src = SRC_FB;
                    if (!empty) begin
                        n_ok  = i_cmd.rd;
                        n_src = SRC_MEM;
                    end
                end
                default: begin
                    n_head = '0;
                    n_tail = '0;
                    n_fill = '0;
                    n_ok   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_res_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok       <= n_ok;
        r_src      <= n_src;
        r_fallback <= i_cmd.fallback;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= i_cmd.data;
        end
        r_rd_data <= r_mem[raddr];
    end

    always_comb begin
        case (r_src)
            SRC_MEM:  o_data_out = OUT_W'(r_rd_data);
            SRC_FB:   o_data_out = r_fallback;
            default:  o_data_out = '0;
        endcase
    end

    assign o_valid = r_res_valid;
    assign o_ok    = r_ok;
    assign o_count = COUNT_W'(r_fill);
    assign o_fill  = r_fill;

endmodule

### sv/ring_buffer_deque_core.sv
// A start is queued, then the back part registers its result and strobes o_valid.
// Throughput: one transaction per cycle; the back part retires a command every cycle.
// The store is a 16-entry single-write, single-read memory with a registered read port.
// Reset (synchronous, active low) empties the deque and the command queue.
// Store contents are not cleared; entries are only read after a push wrote them.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module ring_buffer_deque_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [rbd_pkg::KIND_W-1:0]    i_kind,
    input  logic [31:0]                   i_data_in,
    input  logic [rbd_pkg::OUT_W-1:0]     i_fallback,
    input  logic [rbd_pkg::POS_W-1:0]     i_position,
    output logic                          o_valid,
    output logic                          o_ok,
    output logic [rbd_pkg::OUT_W-1:0]     o_data_out,
    output logic [rbd_pkg::COUNT_W-1:0]   o_count
);
    import rbd_pkg::*;

    // The front part decodes each start transaction into a command and
    // drops it into a short queue. The back part owns the head and tail
    // pointers, the fill count and the store, and retires one command per
    // cycle, so the queue normally holds at most one entry and busy only
    // rises if the back part were ever to fall behind.
    t_cmd             front_cmd, q_cmd;
    t_q_stat          q_stat;
    logic             front_push, back_pop;
    logic [CNT_W-1:0] fill;

    rbd_front u_front (
        .i_start    (i_start),
        .i_kind     (i_kind),
        .i_data_in  (i_data_in),
        .i_fallback (i_fallback),
        .i_position (i_position),
        .i_q_stat   (q_stat),
        .o_busy     (o_busy),
        .o_push     (front_push),
        .o_cmd      (front_cmd)
    );

    rbd_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    // The back part sees a command whenever the queue is not empty and
    // answers it in the following cycle.
    rbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!q_stat.empty),
        .i_cmd      (q_cmd),
        .o_pop      (back_pop),
        .o_valid    (o_valid),
        .o_ok       (o_ok),
        .o_data_out (o_data_out),
        .o_count    (o_count),
        .o_fill     (fill)
    );

    // The fill count never exceeds the capacity of the store.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // Every accepted transaction is followed by its result strobe on o_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("result strobe missing after accepted transaction");

    // A result is never produced without a command having been queued.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(!q_stat.empty))
        else $error("result strobe without a queued command");

endmodule
